[sv/lrc_pkg.sv]
// lrc_pkg: shared types and constants of the line rectangle clipper
`default_nettype none
package lrc_pkg;

  localparam int ParamFrac = 16;
  localparam int DivSteps  = 32;
  localparam int NumLanes  = 4;
  localparam int ProdW     = 33 + ParamFrac + 1;
  localparam int AddrW     = 4;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;
  localparam logic [31:0] T_ONE = 32'(1) << ParamFrac;

  typedef struct packed {
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
  } line_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] clipped_start_x;
    logic [31:0] clipped_start_y;
    logic [31:0] clipped_end_x;
    logic [31:0] clipped_end_y;
  } clip_t;

  typedef struct packed {
    logic [31:0]          sx;
    logic [31:0]          sy;
    logic [31:0]          ex;
    logic [31:0]          ey;
    logic [32:0]          dx;
    logic [32:0]          dy;
    logic [3:0][33:0]     num;
    logic                 zx;
    logic                 zy;
    logic                 rejz;
  } pre_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [32:0] ux;
    logic [32:0] uy;
    logic        dxn;
    logic        dyn;
    logic        zx;
    logic        zy;
    logic        rejz;
    logic [3:0]  neg;
    logic [3:0]  ovf;
  } side_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } div_t;

  typedef struct packed {
    logic [31:0]          sx;
    logic [31:0]          sy;
    logic [31:0]          ex;
    logic [31:0]          ey;
    logic [32:0]          ux;
    logic [32:0]          uy;
    logic                 dxn;
    logic                 dyn;
    logic                 vis;
    logic                 mv0;
    logic                 mv1;
  } fin_t;

endpackage
`default_nettype wire

[sv/line_rect_clipper_unit.sv]
// line_rect_clipper_unit: pipelined clip of line segments against a rectangle
//
// line channel: one segment per item (line_valid, line_stall, line), signed
// Q16.16 endpoints. clip channel: one result item per segment (clip_valid,
// clip_stall, clip) with the visible flag and the clipped endpoints, or the
// input endpoints unchanged when the segment misses the rectangle.
// The rectangle is set through the APB port: left, top, width, height.
// Write it only while no segment is in flight.
// Throughput is one segment per cycle while no result is held by clip_stall;
// the 32 stage restoring divider (four lanes, one quotient bit per stage)
// sets the depth.
// Reset clears all valid bits and the rectangle registers to zero.
// When clip_stall holds a result, the whole pipeline freezes and line_stall
// rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module line_rect_clipper_unit
  import lrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             line_valid,
  output logic                  line_stall,
  input  wire line_t            line,
  output logic                  clip_valid,
  input  wire logic             clip_stall,
  output clip_t                 clip,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] clip_left;
  logic [31:0] clip_top;
  logic [30:0] clip_width;
  logic [30:0] clip_height;

  logic adv;
  assign adv        = !(clip_valid && clip_stall);
  assign line_stall = !adv;
  assign pready     = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LEFT:   clip_left   <= pwdata;
        REG_TOP:    clip_top    <= pwdata;
        REG_WIDTH:  clip_width  <= pwdata[30:0];
        REG_HEIGHT: clip_height <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEFT:   prdata = clip_left;
      REG_TOP:    prdata = clip_top;
      REG_WIDTH:  prdata = {1'b0, clip_width};
      REG_HEIGHT: prdata = {1'b0, clip_height};
      default:    prdata = '0;
    endcase
  end

  // stage 1: deltas, slab offsets, zero delta checks
  logic [32:0] lo_x, hi_x, lo_y, hi_y, sx33, sy33;
  pre_t        pre_next, pre;
  logic        pre_v;

  always_comb begin
    lo_x = {clip_left[31], clip_left};
    lo_y = {clip_top[31], clip_top};
    hi_x = lo_x + {2'b0, clip_width};
    hi_y = lo_y + {2'b0, clip_height};
    sx33 = {line.start_x[31], line.start_x};
    sy33 = {line.start_y[31], line.start_y};
    pre_next.sx = line.start_x;
    pre_next.sy = line.start_y;
    pre_next.ex = line.end_x;
    pre_next.ey = line.end_y;
    pre_next.dx = {line.end_x[31], line.end_x} - sx33;
    pre_next.dy = {line.end_y[31], line.end_y} - sy33;
    pre_next.num[0] = {lo_x[32], lo_x} - {sx33[32], sx33};
    pre_next.num[1] = {hi_x[32], hi_x} - {sx33[32], sx33};
    pre_next.num[2] = {lo_y[32], lo_y} - {sy33[32], sy33};
    pre_next.num[3] = {hi_y[32], hi_y} - {sy33[32], sy33};
    pre_next.zx = (pre_next.dx == '0);
    pre_next.zy = (pre_next.dy == '0);
    pre_next.rejz =
      (pre_next.zx && ($signed(sx33) < $signed(lo_x) || $signed(sx33) > $signed(hi_x))) ||
      (pre_next.zy && ($signed(sy33) < $signed(lo_y) || $signed(sy33) > $signed(hi_y)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_v <= 1'b0;
    end else if (adv) begin
      pre_v <= line_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre <= pre_next;
    end
  end

  // stage 2: magnitudes, signs, divider setup
  side_t sd [0:DivSteps];
  div_t  dv [0:DivSteps][NumLanes];
  logic  dvv [0:DivSteps];

  side_t                   sd0_next;
  div_t                    dv0_next [NumLanes];
  logic [33:0]             mag [NumLanes];
  logic [32+ParamFrac:0]   dvd [NumLanes];
  logic [32:0]             udv [NumLanes];
  logic [33:0]             dx_neg, dy_neg;

  always_comb begin
    dx_neg = {1'b0, pre.dx[32] ? (33'd0 - pre.dx) : pre.dx};
    dy_neg = {1'b0, pre.dy[32] ? (33'd0 - pre.dy) : pre.dy};
    sd0_next.sx   = pre.sx;
    sd0_next.sy   = pre.sy;
    sd0_next.ex   = pre.ex;
    sd0_next.ey   = pre.ey;
    sd0_next.ux   = dx_neg[32:0];
    sd0_next.uy   = dy_neg[32:0];
    sd0_next.dxn  = pre.dx[32];
    sd0_next.dyn  = pre.dy[32];
    sd0_next.zx   = pre.zx;
    sd0_next.zy   = pre.zy;
    sd0_next.rejz = pre.rejz;
    for (int i = 0; i < NumLanes; i++) begin
      udv[i] = (i < 2) ? dx_neg[32:0] : dy_neg[32:0];
      mag[i] = pre.num[i][33] ? (34'd0 - pre.num[i]) : pre.num[i];
      dvd[i] = {mag[i][32:0], ParamFrac'(0)};
      dv0_next[i].rem = 33'(dvd[i] >> 32);
      dv0_next[i].low = dvd[i][31:0];
      dv0_next[i].q   = '0;
      sd0_next.neg[i] = pre.num[i][33] ^ ((i < 2) ? pre.dx[32] : pre.dy[32]);
      sd0_next.ovf[i] = (dv0_next[i].rem >= udv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= pre_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= sd0_next;
      for (int i = 0; i < NumLanes; i++) begin
        dv[0][i] <= dv0_next[i];
      end
    end
  end

  // divider: one quotient bit per stage in each lane
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    div_t        st_next [NumLanes];
    logic [33:0] part [NumLanes];
    logic [32:0] dsr [NumLanes];

    always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
        dsr[i]  = (i < 2) ? sd[k].ux : sd[k].uy;
        part[i] = {dv[k][i].rem, dv[k][i].low[31]};
        st_next[i].low = {dv[k][i].low[30:0], 1'b0};
        if (part[i] >= {1'b0, dsr[i]}) begin
          st_next[i].rem = 33'(part[i] - {1'b0, dsr[i]});
          st_next[i].q   = {dv[k][i].q[30:0], 1'b1};
        end else begin
          st_next[i].rem = part[i][32:0];
          st_next[i].q   = {dv[k][i].q[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k+1] <= sd[k];
        for (int i = 0; i < NumLanes; i++) begin
          dv[k+1][i] <= st_next[i];
        end
      end
    end
  end

  // saturate quotients to t
  side_t       tsd;
  logic [31:0] tq [NumLanes];
  logic [31:0] tq_next [NumLanes];
  logic        tv;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (sd[DivSteps].ovf[i]) begin
        tq_next[i] = sd[DivSteps].neg[i] ? T_MIN : T_MAX;
      end else if (sd[DivSteps].neg[i]) begin
        tq_next[i] = dv[DivSteps][i].q[31] ? T_MIN : (32'd0 - dv[DivSteps][i].q);
      end else begin
        tq_next[i] = dv[DivSteps][i].q[31] ? T_MAX : dv[DivSteps][i].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else if (adv) begin
      tv <= dvv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tsd <= sd[DivSteps];
      for (int i = 0; i < NumLanes; i++) begin
        tq[i] <= tq_next[i];
      end
    end
  end

  // per axis entry and exit
  side_t       msd;
  logic [31:0] in_x, out_x, in_y, out_y;
  logic        mv;
  logic        lt_x, lt_y;

  assign lt_x = $signed(tq[0]) < $signed(tq[1]);
  assign lt_y = $signed(tq[2]) < $signed(tq[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= tv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      msd   <= tsd;
      in_x  <= tsd.zx ? T_MIN : (lt_x ? tq[0] : tq[1]);
      out_x <= tsd.zx ? T_MAX : (lt_x ? tq[1] : tq[0]);
      in_y  <= tsd.zy ? T_MIN : (lt_y ? tq[2] : tq[3]);
      out_y <= tsd.zy ? T_MAX : (lt_y ? tq[3] : tq[2]);
    end
  end

  // visibility decision
  logic [31:0]        tmin, tmax;
  logic               vis_c;
  fin_t               vf_next, vf;
  logic [ParamFrac:0] vt0, vt1;
  logic               vv;

  always_comb begin
    tmin = ($signed(in_x) > $signed(in_y)) ? in_x : in_y;
    tmax = ($signed(out_x) < $signed(out_y)) ? out_x : out_y;
    vis_c = !msd.rejz && !($signed(tmax) < 0 || $signed(tmin) > $signed(tmax) ||
                           $signed(tmin) > $signed(T_ONE));
    vf_next.sx  = msd.sx;
    vf_next.sy  = msd.sy;
    vf_next.ex  = msd.ex;
    vf_next.ey  = msd.ey;
    vf_next.ux  = msd.ux;
    vf_next.uy  = msd.uy;
    vf_next.dxn = msd.dxn;
    vf_next.dyn = msd.dyn;
    vf_next.vis = vis_c;
    vf_next.mv0 = vis_c && ($signed(tmin) > 0);
    vf_next.mv1 = vis_c && ($signed(tmax) < $signed(T_ONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= 1'b0;
    end else if (adv) begin
      vv <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vf  <= vf_next;
      vt0 <= tmin[ParamFrac:0];
      vt1 <= tmax[ParamFrac:0];
    end
  end

  // lerp products
  fin_t             pf;
  logic [ProdW-1:0] p0x, p0y, p1x, p1y;
  logic             pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pf  <= vf;
      p0x <= {{(ProdW-33){1'b0}}, vf.ux} * {{(ProdW-ParamFrac-1){1'b0}}, vt0};
      p0y <= {{(ProdW-33){1'b0}}, vf.uy} * {{(ProdW-ParamFrac-1){1'b0}}, vt0};
      p1x <= {{(ProdW-33){1'b0}}, vf.ux} * {{(ProdW-ParamFrac-1){1'b0}}, vt1};
      p1y <= {{(ProdW-33){1'b0}}, vf.uy} * {{(ProdW-ParamFrac-1){1'b0}}, vt1};
    end
  end

  // rounding, endpoint moves, output register
  logic [ProdW-1:0] half;
  logic [ProdW-1:0] r0x, r0y, r1x, r1y;
  logic [33:0]      c0x, c0y, c1x, c1y;
  clip_t            clip_next;

  always_comb begin
    half = ProdW'(1) << (ParamFrac - 1);
    r0x  = (p0x + half) >> ParamFrac;
    r0y  = (p0y + half) >> ParamFrac;
    r1x  = (p1x + half) >> ParamFrac;
    r1y  = (p1y + half) >> ParamFrac;
    c0x  = pf.dxn ? ({{2{pf.sx[31]}}, pf.sx} - {1'b0, r0x[32:0]})
                  : ({{2{pf.sx[31]}}, pf.sx} + {1'b0, r0x[32:0]});
    c0y  = pf.dyn ? ({{2{pf.sy[31]}}, pf.sy} - {1'b0, r0y[32:0]})
                  : ({{2{pf.sy[31]}}, pf.sy} + {1'b0, r0y[32:0]});
    c1x  = pf.dxn ? ({{2{pf.sx[31]}}, pf.sx} - {1'b0, r1x[32:0]})
                  : ({{2{pf.sx[31]}}, pf.sx} + {1'b0, r1x[32:0]});
    c1y  = pf.dyn ? ({{2{pf.sy[31]}}, pf.sy} - {1'b0, r1y[32:0]})
                  : ({{2{pf.sy[31]}}, pf.sy} + {1'b0, r1y[32:0]});
    clip_next.visible         = pf.vis;
    clip_next.clipped_start_x = pf.mv0 ? c0x[31:0] : pf.sx;
    clip_next.clipped_start_y = pf.mv0 ? c0y[31:0] : pf.sy;
    clip_next.clipped_end_x   = pf.mv1 ? c1x[31:0] : pf.ex;
    clip_next.clipped_end_y   = pf.mv1 ? c1y[31:0] : pf.ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (adv) begin
      clip_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip <= clip_next;
    end
  end

endmodule
`default_nettype wire

[bench/line_rect_clipper_unit_tb.sv]
// line_rect_clipper_unit_tb: self-checking bench for the line rectangle clipper
`default_nettype none
module line_rect_clipper_unit_tb;
  import lrc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic line_valid = 1'b0;
  logic line_stall;
  line_t line = '0;
  logic clip_valid;
  logic clip_stall = 1'b0;
  clip_t clip;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  line_rect_clipper_unit i_dut (
    .clk(clk), .rst(rst),
    .line_valid(line_valid), .line_stall(line_stall), .line(line),
    .clip_valid(clip_valid), .clip_stall(clip_stall), .clip(clip),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam longint TOne = longint'(1) << ParamFrac;
  localparam longint TMaxL = 64'sh7FFF_FFFF;
  localparam longint TMinL = -64'sh8000_0000;

  longint rect_left, rect_top, rect_width, rect_height;
  clip_t clip_queue[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int visible_cnt = 0;
  bit idle_on = 1'b1;

  function automatic longint tquot(longint num, longint den);
    bit neg;
    longint un, ud, q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un << ParamFrac) / ud;
    if (!neg) return q > TMaxL ? TMaxL : q;
    return q > 64'sh8000_0000 ? TMinL : -q;
  endfunction

  function automatic bit slab_range(longint s, longint e, longint lo, longint hi,
                                    output longint tin, output longint tout);
    longint d, t0, t1;
    d = e - s;
    tin = 0;
    tout = 0;
    if (d == 0) begin
      if (s < lo || s > hi) return 1'b0;
      tin = TMinL;
      tout = TMaxL;
      return 1'b1;
    end
    t0 = tquot(lo - s, d);
    t1 = tquot(hi - s, d);
    tin = t0 < t1 ? t0 : t1;
    tout = t0 < t1 ? t1 : t0;
    return 1'b1;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    longint d, ud, r;
    d = b - a;
    ud = d < 0 ? -d : d;
    r = (ud * t + (longint'(1) << (ParamFrac - 1))) >>> ParamFrac;
    return d < 0 ? a - r : a + r;
  endfunction

  function automatic clip_t clip_segment(line_t l);
    clip_t c;
    longint sx, sy, ex, ey, inx, outx, iny, outy, tmin, tmax;
    sx = longint'(signed'(l.start_x));
    sy = longint'(signed'(l.start_y));
    ex = longint'(signed'(l.end_x));
    ey = longint'(signed'(l.end_y));
    c.visible = 1'b0;
    c.clipped_start_x = l.start_x;
    c.clipped_start_y = l.start_y;
    c.clipped_end_x = l.end_x;
    c.clipped_end_y = l.end_y;
    if (slab_range(sx, ex, rect_left, rect_left + rect_width, inx, outx) &&
        slab_range(sy, ey, rect_top, rect_top + rect_height, iny, outy)) begin
      tmin = inx > iny ? inx : iny;
      tmax = outx < outy ? outx : outy;
      if (!(tmax < 0 || tmin > tmax || tmin > TOne)) begin
        c.visible = 1'b1;
        if (tmin > 0) begin
          c.clipped_start_x = 32'(blend(sx, ex, tmin));
          c.clipped_start_y = 32'(blend(sy, ey, tmin));
        end
        if (tmax < TOne) begin
          c.clipped_end_x = 32'(blend(sx, ex, tmax));
          c.clipped_end_y = 32'(blend(sy, ey, tmax));
        end
      end
    end
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEFT: rect_left = longint'(signed'(value));
      REG_TOP: rect_top = longint'(signed'(value));
      REG_WIDTH: rect_width = longint'(value[30:0]);
      default: rect_height = longint'(value[30:0]);
    endcase
  endtask

  task automatic set_rect(logic [31:0] l, logic [31:0] t, logic [31:0] w, logic [31:0] h);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_line(line_t l);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      line_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line <= l;
    line_valid <= 1'b1;
    do @(posedge clk); while (line_stall);
    clip_queue.push_back(clip_segment(l));
    sent++;
  endtask

  task automatic drain;
    line_valid <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord(longint base, longint span);
    longint v;
    v = base + $signed($urandom_range(0, 2 * 32'(span) + 8)) - 4 - span / 2;
    return 32'(v);
  endfunction

  function automatic line_t rand_line(bit wide);
    line_t l;
    if (wide) begin
      l = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      l.start_x = near_coord(rect_left, rect_width + 64);
      l.end_x = $urandom_range(0, 7) == 0 ? l.start_x : near_coord(rect_left, rect_width + 64);
      l.start_y = near_coord(rect_top, rect_height + 64);
      l.end_y = $urandom_range(0, 7) == 0 ? l.start_y : near_coord(rect_top, rect_height + 64);
    end
    return l;
  endfunction

  always @(posedge clk) begin
    if (!rst && clip_valid && !clip_stall) begin
      if (clip_queue.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        clip_t e;
        e = clip_queue.pop_front();
        checked++;
        if (e.visible) visible_cnt++;
        if (clip.visible !== e.visible) begin
          $error("visible exp %0d got %0d", e.visible, clip.visible); errors++;
        end
        if (clip.clipped_start_x !== e.clipped_start_x) begin
          $error("clipped_start_x exp %h got %h", e.clipped_start_x, clip.clipped_start_x);
          errors++;
        end
        if (clip.clipped_start_y !== e.clipped_start_y) begin
          $error("clipped_start_y exp %h got %h", e.clipped_start_y, clip.clipped_start_y);
          errors++;
        end
        if (clip.clipped_end_x !== e.clipped_end_x) begin
          $error("clipped_end_x exp %h got %h", e.clipped_end_x, clip.clipped_end_x);
          errors++;
        end
        if (clip.clipped_end_y !== e.clipped_end_y) begin
          $error("clipped_end_y exp %h got %h", e.clipped_end_y, clip.clipped_end_y);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) begin
      clip_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      clip_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      clip_stall <= 1'b1;
    end else begin
      clip_stall <= 1'b0;
    end
  end

  task automatic test_directed;
    rect_left = 0; rect_top = 0; rect_width = 0; rect_height = 0;
    send_line('{32'h0, 32'h0, 32'h0, 32'h0});
    drain();
    set_rect(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0003_0000);
    send_line('{32'h0, 32'h0003_0000, 32'h0008_0000, 32'h0003_0000});
    send_line('{32'h0002_0000, 32'h0, 32'h0002_0000, 32'h0008_0000});
    send_line('{32'h0002_0000, 32'h0003_0000, 32'h0003_0000, 32'h0004_0000});
    send_line('{32'h0, 32'h0, 32'h0, 32'h0008_0000});
    send_line('{32'h0, 32'h0, 32'h0008_0000, 32'h0});
    send_line('{32'h0, 32'h0, 32'h0008_0000, 32'h0008_0000});
    send_line('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_line('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_line('{32'h0002_0000, 32'h0003_0000, 32'h0002_0001, 32'h0003_0000});
    send_line('{32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0005_0000});
    send_line('{32'hFFFF_FFFF, 32'h0003_0000, 32'h0000_0001, 32'h0003_0000});
    drain();
    set_rect(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_line('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_line('{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_line('{32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000});
    drain();
    set_rect(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_line('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_line('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    drain();
  endtask

  task automatic test_random_rects;
    for (int phase = 0; phase < 8; phase++) begin
      set_rect($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF),
               $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF),
               phase == 3 ? 32'h0 : (phase == 5 ? $urandom : $urandom_range(0, 32'h00FF_FFFF)),
               phase == 4 ? 32'h0 : (phase == 6 ? $urandom : $urandom_range(0, 32'h00FF_FFFF)));
      if (phase == 7) idle_on = 1'b0;
      for (int i = 0; i < 250; i++) send_line(rand_line($urandom_range(0, 4) == 0));
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_rects();
    $display("tb: sent %0d segments, checked %0d results, %0d visible",
             sent, checked, visible_cnt);
    if (errors == 0 && clip_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

[line_rect_clipper_unit.f]
sv/lrc_pkg.sv
sv/line_rect_clipper_unit.sv
bench/line_rect_clipper_unit_tb.sv
